[rtl/core/cs_pkg.sv]
// ----------------------------------------------------------------------------
// cs_pkg
// Types and codes shared by the cosine similarity controller and datapath.
// ----------------------------------------------------------------------------
package cs_pkg;

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last_elem;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               degenerate;
    } t_out_item;

    typedef enum logic [2:0] {
        S_ACC,
        S_START,
        S_PMUL,
        S_RMUL,
        S_ITER,
        S_TMUL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_PROD,
        MUL_RHS,
        MUL_TRIAL
    } t_mul_op;

    typedef struct packed {
        logic    acc_en;
        logic    start;
        logic    mul_load;
        t_mul_op mul_op;
        logic    mul_step;
        logic    store_prod;
        logic    store_rhs;
        logic    search_init;
        logic    search_upd;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic mul_done;
        logic search_done;
    } t_status;

endpackage

[rtl/core/cs_datapath.sv]
// ----------------------------------------------------------------------------
// cs_datapath
// Accumulators, digit-serial multiplier, rounding search and result register.
// ----------------------------------------------------------------------------
module cs_datapath
    import cs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_item o_item
);

    logic signed [41:0] r_dot;
    logic [40:0]        r_na, r_nb;
    logic [81:0]        r_prod;
    logic [115:0]       r_rhs;
    logic [115:0]       r_mul_a, r_acc;
    logic [47:0]        r_mul_b;
    logic [15:0]        r_lo, r_hi, r_m;
    logic               r_neg, r_degen;
    t_out_item          r_out;

    logic signed [31:0] w_ab, w_aa, w_bb;
    logic signed [42:0] w_dot_sum;
    logic [41:0]        w_na_sum, w_nb_sum;
    logic [41:0]        w_mag;
    logic [15:0]        w_m, w_t;
    logic [31:0]        w_tt;
    logic               w_le;
    logic signed [15:0] w_sim;

    always_comb begin
        w_ab      = i_item.elem_a * i_item.elem_b;
        w_aa      = i_item.elem_a * i_item.elem_a;
        w_bb      = i_item.elem_b * i_item.elem_b;
        w_dot_sum = 43'(r_dot) + 43'(w_ab);
        w_na_sum  = 42'(r_na) + 42'(w_aa[30:0]);
        w_nb_sum  = 42'(r_nb) + 42'(w_bb[30:0]);
        w_mag     = r_dot[41] ? 42'(-r_dot) : 42'(r_dot);
        w_m       = 16'((17'(r_lo) + 17'(r_hi) + 17'd1) >> 1);
        w_t       = 16'({w_m, 1'b0} - 17'd1);
        w_tt      = w_t * w_t;
        w_le      = r_acc <= r_rhs;
        if (r_degen) begin
            w_sim = '0;
        end else if (r_neg) begin
            w_sim = 16'(-17'(r_lo));
        end else if (r_lo[15]) begin
            w_sim = 16'h7FFF;
        end else begin
            w_sim = r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (i_cmd.load_out) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (i_cmd.acc_en) begin
            if (w_dot_sum[42] != w_dot_sum[41]) begin
                r_dot <= w_dot_sum[42] ? {1'b1, 41'd0} : {1'b0, {41{1'b1}}};
            end else begin
                r_dot <= w_dot_sum[41:0];
            end
            r_na <= w_na_sum[41] ? {41{1'b1}} : w_na_sum[40:0];
            r_nb <= w_nb_sum[41] ? {41{1'b1}} : w_nb_sum[40:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_neg   <= r_dot[41];
            r_degen <= (r_na == '0) || (r_nb == '0);
        end
        if (i_cmd.mul_load) begin
            r_acc <= '0;
            unique case (i_cmd.mul_op)
                MUL_PROD: begin
                    r_mul_a <= 116'(r_na);
                    r_mul_b <= 48'(r_nb);
                end
                MUL_RHS: begin
                    r_mul_a <= 116'(w_mag);
                    r_mul_b <= 48'(w_mag);
                end
                default: begin
                    r_mul_a <= 116'(r_prod);
                    r_mul_b <= 48'(w_tt);
                    r_m     <= w_m;
                end
            endcase
        end else if (i_cmd.mul_step) begin
            r_acc   <= r_acc + 116'(r_mul_a * r_mul_b[7:0]);
            r_mul_a <= r_mul_a << 8;
            r_mul_b <= r_mul_b >> 8;
        end
        if (i_cmd.store_prod) begin
            r_prod <= r_acc[81:0];
        end
        if (i_cmd.store_rhs) begin
            r_rhs <= {r_acc[83:0], 32'd0};
        end
        if (i_cmd.search_init) begin
            r_lo <= '0;
            r_hi <= 16'h8000;
        end else if (i_cmd.search_upd) begin
            if (w_le) begin
                r_lo <= r_m;
            end else begin
                r_hi <= r_m - 16'd1;
            end
        end
        if (i_cmd.load_out) begin
            r_out.similarity <= w_sim;
            r_out.degenerate <= r_degen;
        end
    end

    assign o_status.degen       = (r_na == '0) || (r_nb == '0);
    assign o_status.mul_done    = r_mul_b == '0;
    assign o_status.search_done = r_lo >= r_hi;
    assign o_item               = r_out;

`ifndef SYNTHESIS
    a_upd_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search_upd |-> (r_lo < r_hi))
        else $error("search step with closed interval");
    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search_upd |-> (r_m > r_lo && r_m <= r_hi))
        else $error("trial point outside interval");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_degen |=> (r_out.similarity == '0 && r_out.degenerate))
        else $error("degenerate result not zero");
`endif

endmodule

[rtl/core/cs_ctrl.sv]
// ----------------------------------------------------------------------------
// cs_ctrl
// Sequencer: accumulation, norm products, rounding search, result handover.
// ----------------------------------------------------------------------------
module cs_ctrl
    import cs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc_en = 1'b1;
                    if (i_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                if (i_status.degen) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_load = 1'b1;
                    o_cmd.mul_op   = MUL_PROD;
                    n_state        = S_PMUL;
                end
            end
            S_PMUL: begin
                if (i_status.mul_done) begin
                    o_cmd.store_prod = 1'b1;
                    o_cmd.mul_load   = 1'b1;
                    o_cmd.mul_op     = MUL_RHS;
                    n_state          = S_RMUL;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_RMUL: begin
                if (i_status.mul_done) begin
                    o_cmd.store_rhs   = 1'b1;
                    o_cmd.search_init = 1'b1;
                    n_state           = S_ITER;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_ITER: begin
                if (i_status.search_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_load = 1'b1;
                    o_cmd.mul_op   = MUL_TRIAL;
                    n_state        = S_TMUL;
                end
            end
            S_TMUL: begin
                if (i_status.mul_done) begin
                    o_cmd.search_upd = 1'b1;
                    n_state          = S_ITER;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_ready_only_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid && i_last |=> (r_state == S_START))
        else $error("last item did not start the result sequence");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");
    a_mul_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TMUL) && i_status.mul_done |=> (r_state == S_ITER))
        else $error("trial product not compared");
`endif

endmodule

[rtl/core/cosine_similarity.sv]
// ----------------------------------------------------------------------------
// cosine_similarity
// Streaming cosine similarity of two vectors, Q4.12 in, Q1.15 out.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, i_in_item): one element pair per
// item, accepted one per cycle while accumulating. The item with last_elem
// set closes the vectors; the block then stops accepting until its result
// is in the output register.
// Output channel (o_out_valid / i_out_ready, o_out_item): one item per
// vector pair, carrying similarity and the degenerate flag.
// After the last item the shared digit-serial multiplier (8 bits of
// multiplier per cycle) forms the norm product and the squared dot
// product, then up to 16 search steps each multiply the norm product by
// a squared trial point. A zero norm skips this and goes to the result.
// A stalled receiver holds the result; the next vector may accumulate in
// the meantime, and only its own result waits for the slot to free.
// Reset clears the accumulators, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module cosine_similarity
    import cs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd    w_cmd;
    t_status w_status;

    cs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_in_item.last_elem),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_item   (o_out_item)
    );

endmodule

[tb/sv/tb_cosine_similarity.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cosine_similarity
// Streams vector element pairs into cosine_similarity under random source
// gaps and sink stalls, predicts each similarity result exactly in integer
// arithmetic and checks every output item against it in order.
// ----------------------------------------------------------------------------
module tb_cosine_similarity;
    import cs_pkg::*;

    localparam longint DOT_HI  = 64'sd2199023255551;
    localparam longint DOT_LO  = -64'sd2199023255552;
    localparam longint NORM_HI = 64'sd2199023255551;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    cosine_similarity i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    t_in_item  pending_pairs[$];
    t_out_item expected_sims[$];
    longint    dot_sum, norm_a_sum, norm_b_sum;
    int        mismatches, n_vectors, n_degen, n_pairs;
    int        src_gap, snk_gap;
    bit        no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // exact similarity: largest m with (2m-1)^2 * na * nb <= 2^32 * dot^2
    task automatic predict_pair(input t_in_item it, output bit have, output t_out_item r);
        longint a, b, d, na, nb, mag, t, sim;
        logic [127:0] prod, rhs, trial;
        int lo, hi, mm;
        a = it.elem_a;
        b = it.elem_b;
        d = dot_sum + a * b;
        if (d > DOT_HI) d = DOT_HI;
        if (d < DOT_LO) d = DOT_LO;
        na = norm_a_sum + a * a;
        if (na > NORM_HI) na = NORM_HI;
        nb = norm_b_sum + b * b;
        if (nb > NORM_HI) nb = NORM_HI;
        dot_sum = d;
        norm_a_sum = na;
        norm_b_sum = nb;
        have = it.last_elem;
        r = '0;
        if (it.last_elem) begin
            if (na == 0 || nb == 0) begin
                r.degenerate = 1'b1;
            end else begin
                mag = (d < 0) ? -d : d;
                prod = {64'b0, na} * {64'b0, nb};
                rhs = ({64'b0, mag} * {64'b0, mag}) << 32;
                lo = 0;
                hi = 32768;
                while (lo < hi) begin
                    mm = (lo + hi + 1) >> 1;
                    t = 2 * mm - 1;
                    trial = prod * {64'b0, t * t};
                    if (trial <= rhs) lo = mm;
                    else hi = mm - 1;
                end
                sim = (d < 0) ? -longint'(lo) : longint'(lo);
                if (sim > 32767) sim = 32767;
                r.similarity = sim[15:0];
            end
            dot_sum = 0;
            norm_a_sum = 0;
            norm_b_sum = 0;
        end
    endtask

    task automatic add_pair(input int a, input int b, input bit last);
        t_in_item it;
        it.elem_a = a[15:0];
        it.elem_b = b[15:0];
        it.last_elem = last;
        pending_pairs.push_back(it);
    endtask

    // random vector; style picks independent, correlated or anti-correlated b
    task automatic add_vector(input int len);
        int a, b, style, j, sh;
        style = $urandom_range(0, 3);
        sh = $urandom_range(0, 15);
        for (j = 0; j < len; j++) begin
            a = $signed(16'($urandom)) >>> sh;
            case (style)
                0: b = $signed(16'($urandom)) >>> sh;
                1: b = a + $urandom_range(0, 3) - 1;
                2: b = -a;
                default: b = a;
            endcase
            if (b > 32767) b = 32767;
            if (b < -32768) b = -32768;
            add_pair(a, b, j == len - 1);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        bit        have;
        t_out_item r;
        bit        nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_item <= '0;
            src_gap <= 0;
        end else begin
            nv = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_pair(i_in_item, have, r);
                n_pairs++;
                if (have) begin
                    expected_sims.push_back(r);
                    n_vectors++;
                    if (r.degenerate) n_degen++;
                end
                nv = 1'b0;
            end
            if (!nv) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                end else if (pending_pairs.size() > 0) begin
                    i_in_item <= pending_pairs.pop_front();
                    nv = 1'b1;
                    src_gap <= draw_gap();
                end
            end
            i_in_valid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_sims.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: sim %0d degen %0d",
                                 o_out_item.similarity, o_out_item.degenerate);
                end else begin
                    e = expected_sims.pop_front();
                    if (o_out_item !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp sim %0d degen %0d, got sim %0d degen %0d",
                                     e.similarity, e.degenerate,
                                     o_out_item.similarity, o_out_item.degenerate);
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                snk_gap <= draw_gap();
            end
        end
    end

    initial begin
        int k;
        mismatches = 0;
        n_vectors = 0;
        n_degen = 0;
        n_pairs = 0;
        no_idle = 1'b0;
        dot_sum = 0;
        norm_a_sum = 0;
        norm_b_sum = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        add_pair(32767, 32767, 1'b1);
        add_pair(-32768, -32768, 1'b1);
        add_pair(32767, -32768, 1'b1);
        add_pair(-32768, 32767, 1'b1);
        add_pair(0, 1234, 1'b1);
        add_pair(-77, 0, 1'b1);
        add_pair(0, 0, 1'b1);
        add_pair(4096, 0, 1'b0);
        add_pair(0, 4096, 1'b1);
        add_pair(1, 1, 1'b0);
        add_pair(1, -1, 1'b1);
        add_pair(3, 4, 1'b0);
        add_pair(4, -3, 1'b1);
        add_pair(1, 32767, 1'b1);
        add_pair(-1, -1, 1'b1);
        add_pair(0, 0, 1'b0);
        add_pair(5, 5, 1'b1);
        // long full-scale vectors
        for (k = 0; k < 100; k++) add_pair(-32768, -32768, k == 99);
        for (k = 0; k < 100; k++) add_pair(-32768, 32767, k == 99);

        // random
        for (k = 0; k < 60; k++) begin
            no_idle = (k % 30) >= 25;
            if ($urandom_range(0, 19) == 0) add_vector($urandom_range(20, 60));
            else add_vector($urandom_range(1, 6));
            wait (pending_pairs.size() < 8);
        end
        wait (pending_pairs.size() == 0 && !i_in_valid);
        wait (expected_sims.size() == 0);
        repeat (300) @(posedge i_clk);
        if (expected_sims.size() != 0) mismatches++;
        $display("covered %0d vectors (%0d degenerate) from %0d element pairs",
                 n_vectors, n_degen, n_pairs);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cs_pkg.sv
rtl/core/cs_datapath.sv
rtl/core/cs_ctrl.sv
rtl/core/cosine_similarity.sv
tb/sv/tb_cosine_similarity.sv
